// ----- rtl/png_scanline_unfilter_assert.svh -----
// assertion macros for the png scanline unfilter checker
// no dependencies; taken in by `include
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// clocked assertion, ignored while reset is asserted
`define PSU_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("png_scanline_unfilter assertion failed");

// clocked assertion that also holds through reset
`define PSU_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("png_scanline_unfilter assertion failed");

`endif

// ----- rtl/psu_pkg.sv -----
// shared types, constants and helpers of the png scanline unfilter
// no dependencies
`default_nettype none

package psu_pkg;

    localparam int MAX_ROW_BYTES = 16384;
    localparam int COL_W         = $clog2(MAX_ROW_BYTES);
    localparam int LEN_W         = $clog2(MAX_ROW_BYTES + 1);
    localparam int CFG_LEN_W     = 15;
    localparam int CFG_BPP_W     = 3;
    localparam int MAX_BPP       = 4;
    localparam int PH_W          = 2;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam logic [3:0] PHASE_WRAP = 4'd11;

    localparam logic [0:0] REG_ROW_LENGTH      = 1'b0;
    localparam logic [0:0] REG_BYTES_PER_PIXEL = 1'b1;

    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_SUB   = 3'd1,
        FLT_UP    = 3'd2,
        FLT_AVG   = 3'd3,
        FLT_PAETH = 3'd4
    } filter_t;

    localparam logic [7:0] MAX_FILTER_CODE = 8'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       image_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       row_end;
        logic       filter_error;
    } out_item_t;

    typedef struct packed {
        logic [LEN_W-1:0]     row_len;
        logic [CFG_BPP_W-1:0] bpp;
    } cfg_t;

    // one sample byte handed from the front end to the reconstruction stage
    typedef struct packed {
        logic [7:0]       data_byte;
        filter_t          filter;
        logic             first_row;
        logic             last;
        logic             bad;
        logic [PH_W-1:0]  ph;
        logic [COL_W-1:0] col;
    } issue_t;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic [7:0]       data;
    } row_wr_t;

    // column mod bpp from column mod 12 (12 is a multiple of every bpp)
    function automatic logic [PH_W-1:0] phase_of(input logic [3:0] mod12,
                                                 input logic [CFG_BPP_W-1:0] bpp);
        logic [PH_W-1:0] ph;
        ph = '0;
        case (bpp)
            3'd2: ph = {1'b0, mod12[0]};
            3'd3: begin
                case (mod12)
                    4'd1, 4'd4, 4'd7, 4'd10: ph = 2'd1;
                    4'd2, 4'd5, 4'd8, 4'd11: ph = 2'd2;
                    default:                 ph = 2'd0;
                endcase
            end
            3'd4: ph = mod12[1:0];
            default: ph = '0;
        endcase
        return ph;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/psu_ram.sv -----
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/psu_regs.sv -----
// apb configuration registers: row length and bytes per pixel, with clamping
// depends on psu_pkg
`default_nettype none

module psu_regs
    import psu_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output cfg_t                       cfg
);

    logic [CFG_LEN_W-1:0] row_length_reg;
    logic [CFG_BPP_W-1:0] bpp_reg;
    logic                 wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg <= CFG_LEN_W'(1);
            bpp_reg        <= CFG_BPP_W'(1);
        end else if (wr_en) begin
            if (paddr[2] == REG_ROW_LENGTH) begin
                row_length_reg <= pwdata[CFG_LEN_W-1:0];
            end else begin
                bpp_reg <= pwdata[CFG_BPP_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_BYTES_PER_PIXEL) begin
            prdata = APB_DATA_W'(bpp_reg);
        end else begin
            prdata = APB_DATA_W'(row_length_reg);
        end
    end

    // out of range values act as the nearest legal one
    always_comb begin
        if (row_length_reg == '0) begin
            cfg.row_len = LEN_W'(1);
        end else if (32'(row_length_reg) > 32'(MAX_ROW_BYTES)) begin
            cfg.row_len = LEN_W'(MAX_ROW_BYTES);
        end else begin
            cfg.row_len = LEN_W'(row_length_reg);
        end
        if (bpp_reg == '0) begin
            cfg.bpp = CFG_BPP_W'(1);
        end else if (32'(bpp_reg) > 32'(MAX_BPP)) begin
            cfg.bpp = CFG_BPP_W'(MAX_BPP);
        end else begin
            cfg.bpp = bpp_reg;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/psu_recon.sv -----
// reconstruction stage: pixel histories, predictor, row store write back
// and result register; depends on psu_pkg
`default_nettype none

module psu_recon
    import psu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       issue_valid,
    input  issue_t          issue,
    input  wire logic       hist_clear,
    input  wire logic [7:0] above_byte,
    output logic            stage_ready,
    output row_wr_t         row_wr,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data
);

    logic       s1_valid_reg, s1_valid_next;
    issue_t     s1_reg;
    logic [7:0] left_reg [MAX_BPP];
    logic [7:0] above_left_reg [MAX_BPP];
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg;

    logic       adv;
    logic [7:0] a, b, c, pred, x;
    logic [8:0] ab_sum;
    logic signed [9:0] d_bc, d_ac, d_abc;
    logic [9:0] pa, pb, pc;

    function automatic logic [9:0] abs10(input logic signed [9:0] v);
        return v[9] ? 10'(-v) : 10'(v);
    endfunction

    assign adv         = s1_valid_reg && (!out_valid_reg || m_ready);
    assign stage_ready = !s1_valid_reg || adv;

    assign a = left_reg[s1_reg.ph];
    assign c = above_left_reg[s1_reg.ph];
    assign b = s1_reg.first_row ? 8'd0 : above_byte;

    assign ab_sum = {1'b0, a} + {1'b0, b};
    assign d_bc   = $signed({2'b00, b}) - $signed({2'b00, c});
    assign d_ac   = $signed({2'b00, a}) - $signed({2'b00, c});
    assign d_abc  = d_bc + d_ac;
    assign pa     = abs10(d_bc);
    assign pb     = abs10(d_ac);
    assign pc     = abs10(d_abc);

    always_comb begin
        case (s1_reg.filter)
            FLT_SUB:   pred = a;
            FLT_UP:    pred = b;
            FLT_AVG:   pred = ab_sum[8:1];
            FLT_PAETH: begin
                if (pa <= pb && pa <= pc) begin
                    pred = a;
                end else if (pb <= pc) begin
                    pred = b;
                end else begin
                    pred = c;
                end
            end
            default:   pred = 8'd0;
        endcase
    end

    assign x = s1_reg.data_byte + pred;

    assign row_wr.en   = adv;
    assign row_wr.addr = s1_reg.col;
    assign row_wr.data = x;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (issue_valid) begin
            s1_valid_next = 1'b1;
        end else if (adv) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (adv) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_BPP; i++) begin
                left_reg[PH_W'(i)]       <= 8'd0;
                above_left_reg[PH_W'(i)] <= 8'd0;
            end
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            // a filter byte starts a new row and wins over a late write
            if (hist_clear) begin
                for (int i = 0; i < MAX_BPP; i++) begin
                    left_reg[PH_W'(i)]       <= 8'd0;
                    above_left_reg[PH_W'(i)] <= 8'd0;
                end
            end else if (adv) begin
                left_reg[s1_reg.ph]       <= x;
                above_left_reg[s1_reg.ph] <= b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue_valid) begin
            s1_reg <= issue;
        end
        if (adv) begin
            out_reg.pixel_byte   <= x;
            out_reg.row_end      <= s1_reg.last;
            out_reg.filter_error <= s1_reg.bad;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ----- rtl/png_scanline_unfilter.sv -----
// top level of the png scanline unfilter: row tracking front end, row store
// ram, reconstruction stage and apb registers; depends on psu_pkg, psu_ram,
// psu_regs and psu_recon
//
// Rebuilds PNG filter method 0 scanlines from the inflated image stream, one
// byte per request. The first byte of every row is the filter type (None,
// Sub, Up, Average, Paeth); the following row_length bytes are filtered
// samples and each yields one reconstructed pixel_byte, with row_end on the
// last one and filter_error on every byte of a row whose type was above 4
// (decoded as None). A set image_start makes its byte the filter type of a
// new first row, dropping any partial row; on a first row the row above reads
// as zero. The block takes one request per cycle, filter bytes included,
// unless the stage holds a sample stalled by a waiting result. The previous
// row's byte is read from the row store ram (MAX_ROW_BYTES x 8) as the
// sample enters the stage register; the stage then predicts, writes back
// into the same column and loads the result register once it is free.
// The result register lets a new request in while a result waits. The row
// store needs no clearing after reset; columns that no earlier row of the
// image wrote read as undefined. Registers (apb, 32 bit data): row_length at
// 0x0, bytes_per_pixel at 0x4; write them only while the block is idle.
`default_nettype none

module png_scanline_unfilter
    import psu_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input byte stream
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  in_item_t                   s_data,
    // reconstructed bytes
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t    cfg;
    issue_t  issue;
    row_wr_t row_wr;
    logic    stage_ready;
    logic [7:0] above_byte;

    // front end row state
    logic [COL_W-1:0] col_reg, col_next;
    logic [3:0]       mod12_reg, mod12_next;   // column mod 12 for the pixel phase
    logic             await_reg, await_next;   // next byte is a filter type
    logic             first_row_reg, first_row_next;
    logic             bad_reg, bad_next;
    filter_t          filter_reg, filter_next;

    logic             accept;
    logic             take_filter;
    logic             last;
    logic [COL_W:0]   col_plus;
    logic             issue_valid;
    logic             hist_clear;

    assign pready = 1'b1;

    assign s_ready     = stage_ready;
    assign accept      = s_valid && s_ready;
    // image start forces a filter byte even in the middle of a row
    assign take_filter = await_reg || s_data.image_start;
    assign col_plus    = {1'b0, col_reg} + (COL_W+1)'(1);
    // a row length shrunk below the current column ends the row here
    assign last        = 32'(col_plus) >= 32'(cfg.row_len);
    assign issue_valid = accept && !take_filter;
    assign hist_clear  = accept && take_filter;

    always_comb begin
        issue.data_byte = s_data.data_byte;
        issue.filter    = filter_reg;
        issue.first_row = first_row_reg;
        issue.last      = last;
        issue.bad       = bad_reg;
        issue.ph        = phase_of(mod12_reg, cfg.bpp);
        issue.col       = col_reg;
    end

    always_comb begin
        col_next       = col_reg;
        mod12_next     = mod12_reg;
        await_next     = await_reg;
        first_row_next = first_row_reg;
        bad_next       = bad_reg;
        filter_next    = filter_reg;
        if (accept) begin
            if (take_filter) begin
                // filter type byte: latch the row's filter, restart the column
                bad_next   = s_data.data_byte > MAX_FILTER_CODE;
                filter_next = bad_next ? FLT_NONE : filter_t'(s_data.data_byte[2:0]);
                await_next = 1'b0;
                col_next   = '0;
                mod12_next = 4'd0;
                if (s_data.image_start) begin
                    first_row_next = 1'b1;
                end
            end else if (last) begin
                col_next       = '0;
                mod12_next     = 4'd0;
                await_next     = 1'b1;
                first_row_next = 1'b0;
            end else begin
                col_next   = col_plus[COL_W-1:0];
                mod12_next = (mod12_reg == PHASE_WRAP) ? 4'd0 : mod12_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            mod12_reg     <= 4'd0;
            await_reg     <= 1'b1;
            first_row_reg <= 1'b1;
            bad_reg       <= 1'b0;
            filter_reg    <= FLT_NONE;
        end else begin
            col_reg       <= col_next;
            mod12_reg     <= mod12_next;
            await_reg     <= await_next;
            first_row_reg <= first_row_next;
            bad_reg       <= bad_next;
            filter_reg    <= filter_next;
        end
    end

    // the previous row's column is read as the sample is taken; its write back
    // always lands before the next row's read thanks to the filter byte between
    psu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_row_store (
        .clk   (aclk),
        .we    (row_wr.en),
        .waddr (row_wr.addr),
        .wdata (row_wr.data),
        .re    (issue_valid),
        .raddr (col_reg),
        .rdata (above_byte)
    );

    psu_recon u_recon (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .issue_valid (issue_valid),
        .issue       (issue),
        .hist_clear  (hist_clear),
        .above_byte  (above_byte),
        .stage_ready (stage_ready),
        .row_wr      (row_wr),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    psu_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

endmodule

`default_nettype wire

// ----- rtl/png_scanline_unfilter_checker.sv -----
// port level checker for the png scanline unfilter, bound to the top level
// depends on psu_pkg and png_scanline_unfilter_assert.svh
`default_nettype none

`include "png_scanline_unfilter_assert.svh"

module png_scanline_unfilter_checker
    import psu_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input in_item_t                   s_data,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input out_item_t                  m_data
);

    // a stalled result holds
    `PSU_ASSERT_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // reset empties the result register
    `PSU_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

    // a fresh result only follows a request that was taken
    `PSU_ASSERT_RST(a_result_latency, aclk, aresetn, $rose(m_valid) |-> $past(s_valid && s_ready, 2))

    // an image start byte is a filter type and gives no result
    `PSU_ASSERT_RST(a_start_no_result, aclk, aresetn, s_valid && s_ready && s_data.image_start |-> ##2 !$rose(m_valid))

endmodule

bind png_scanline_unfilter png_scanline_unfilter_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
